// File: rtl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

    // Bits in one bus byte
    localparam int BITS_PER_BYTE = 8;

    // Function codes carried by an input item
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_ACK   = 3'd3;
    localparam logic [2:0] FUNC_WRITE = 3'd4;
    localparam logic [2:0] FUNC_READ  = 3'd5;

    // Phase numbering of the byte sequences
    localparam logic [5:0] WR_ACK_PHASE  = 6'(2 * BITS_PER_BYTE);
    localparam logic [5:0] RD_LAST_PHASE = 6'(3 * BITS_PER_BYTE - 1);
    localparam logic [3:0] BYTE_BITS     = 4'(BITS_PER_BYTE);

    // Read bit slots: SCL high, sample and SCL low, idle
    localparam logic [1:0] RD_SLOT_HIGH   = 2'd0;
    localparam logic [1:0] RD_SLOT_SAMPLE = 2'd1;
    localparam logic [1:0] RD_SLOT_IDLE   = 2'd2;

    // Active sequence, one-hot
    typedef enum logic [5:0] {
        CMD_IDLE  = 6'b000001,
        CMD_START = 6'b000010,
        CMD_STOP  = 6'b000100,
        CMD_ACK   = 6'b001000,
        CMD_WRITE = 6'b010000,
        CMD_READ  = 6'b100000
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data;
        logic       ack_level;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_en;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
        logic       rejected;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/i2cm_core.sv
`default_nettype none

module i2cm_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire i2cm_pkg::t_in_item i_item,
    input  wire logic [15:0]        i_phase_ticks,
    output i2cm_pkg::t_out_item     o_result
);
    import i2cm_pkg::*;

    t_cmd        r_cmd, n_cmd;
    logic [5:0]  r_phase, n_phase;
    logic [15:0] r_div, n_div;
    logic [7:0]  r_shift, n_shift;
    logic [3:0]  r_bit, n_bit;
    logic [1:0]  r_sub, n_sub;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_sda_en, n_sda_en;
    logic        r_ack, n_ack;
    logic [7:0]  r_read, n_read;

    logic        busy;
    logic        phase_end;
    logic        fin;
    logic        rej;
    logic [15:0] div_inc;
    logic [15:0] lim;
    logic [7:0]  shift_nx;
    logic [3:0]  bit_nx;

    assign busy     = (r_cmd != CMD_IDLE);
    assign div_inc  = r_div + 16'd1;
    assign lim      = (i_phase_ticks == 16'd0) ? 16'd1 : i_phase_ticks;
    assign shift_nx = {r_shift[6:0], 1'b0};
    assign bit_nx   = r_bit + 4'd1;

    // Next state for one item
    always_comb begin
        n_cmd     = r_cmd;
        n_phase   = r_phase;
        n_div     = r_div;
        n_shift   = r_shift;
        n_bit     = r_bit;
        n_sub     = r_sub;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_sda_en  = r_sda_en;
        n_ack     = r_ack;
        n_read    = r_read;
        phase_end = 1'b0;
        fin       = 1'b0;
        rej       = 1'b0;

        // Tick: divide down to phase ends
        if (i_item.func == FUNC_TICK) begin
            if (busy) begin
                n_div = div_inc;
                if (div_inc >= lim) begin
                    n_div     = 16'd0;
                    phase_end = 1'b1;
                end
            end
        end else if (i_item.func <= FUNC_READ) begin
            if (busy) begin
                rej = 1'b1;
            end else begin
                n_phase = 6'd0;
                n_div   = 16'd0;
                n_bit   = 4'd0;
                n_sub   = RD_SLOT_HIGH;
                unique case (i_item.func)
                    FUNC_START: begin
                        n_cmd    = CMD_START;
                        n_sda_en = 1'b1;
                        n_sda    = 1'b1;
                        n_scl    = 1'b1;
                    end
                    FUNC_STOP: begin
                        n_cmd    = CMD_STOP;
                        n_sda_en = 1'b1;
                        n_sda    = 1'b0;
                    end
                    FUNC_ACK: begin
                        n_cmd    = CMD_ACK;
                        n_sda_en = 1'b1;
                        n_sda    = i_item.ack_level;
                    end
                    FUNC_WRITE: begin
                        n_cmd    = CMD_WRITE;
                        n_sda_en = 1'b1;
                        n_shift  = i_item.data;
                        n_sda    = i_item.data[7];
                    end
                    default: begin
                        n_cmd    = CMD_READ;
                        n_sda    = 1'b1;
                        n_sda_en = 1'b0;
                        n_shift  = 8'd0;
                    end
                endcase
            end
        end

        // Pin changes at the end of a phase
        if (phase_end) begin
            unique case (r_cmd)
                CMD_START: begin
                    if (r_phase == 6'd0)      n_sda = 1'b0;
                    else if (r_phase == 6'd1) n_scl = 1'b0;
                    else                      fin   = 1'b1;
                end
                CMD_STOP: begin
                    if (r_phase == 6'd0)      n_scl = 1'b1;
                    else if (r_phase == 6'd1) n_sda = 1'b1;
                    else                      fin   = 1'b1;
                end
                CMD_ACK: begin
                    if (r_phase == 6'd0)      n_scl = 1'b1;
                    else if (r_phase == 6'd1) n_scl = 1'b0;
                    else                      fin   = 1'b1;
                end
                CMD_WRITE: begin
                    if (r_phase < WR_ACK_PHASE) begin
                        if (!r_phase[0]) begin
                            n_scl = 1'b1;
                        end else begin
                            n_scl   = 1'b0;
                            n_shift = shift_nx;
                            n_bit   = bit_nx;
                            if (bit_nx < BYTE_BITS) begin
                                n_sda = shift_nx[7];
                            end else begin
                                // last bit out: let the slave drive the ack
                                n_sda    = 1'b1;
                                n_sda_en = 1'b0;
                            end
                        end
                    end else if (r_phase == WR_ACK_PHASE) begin
                        n_scl = 1'b1;
                    end else begin
                        n_ack = i_item.sda_in;
                        n_scl = 1'b0;
                        fin   = 1'b1;
                    end
                end
                CMD_READ: begin
                    unique case (r_sub)
                        RD_SLOT_HIGH: begin
                            n_scl = 1'b1;
                        end
                        RD_SLOT_SAMPLE: begin
                            n_shift = {r_shift[6:0], i_item.sda_in};
                            n_bit   = bit_nx;
                            n_scl   = 1'b0;
                        end
                        default: ;
                    endcase
                    n_sub = (r_sub == RD_SLOT_IDLE) ? RD_SLOT_HIGH : r_sub + 2'd1;
                    if (r_phase >= RD_LAST_PHASE) begin
                        n_scl  = 1'b0;
                        n_read = n_shift;
                        fin    = 1'b1;
                    end
                end
                default: fin = 1'b1;
            endcase

            if (fin) begin
                n_cmd   = CMD_IDLE;
                n_phase = 6'd0;
                n_sub   = RD_SLOT_HIGH;
            end else begin
                n_phase = r_phase + 6'd1;
            end
        end
    end

    // Result shows the state after the item
    always_comb begin
        o_result.scl_level    = n_scl;
        o_result.sda_level    = n_sda;
        o_result.sda_drive_en = n_sda_en;
        o_result.busy_res     = (n_cmd != CMD_IDLE);
        o_result.done_res     = fin;
        o_result.read_byte    = n_read;
        o_result.ack_seen     = n_ack;
        o_result.rejected     = rej;
    end

    // Engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd    <= CMD_IDLE;
            r_phase  <= 6'd0;
            r_div    <= 16'd0;
            r_shift  <= 8'd0;
            r_bit    <= 4'd0;
            r_sub    <= RD_SLOT_HIGH;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_sda_en <= 1'b1;
            r_ack    <= 1'b0;
            r_read   <= 8'd0;
        end else if (i_step) begin
            r_cmd    <= n_cmd;
            r_phase  <= n_phase;
            r_div    <= n_div;
            r_shift  <= n_shift;
            r_bit    <= n_bit;
            r_sub    <= n_sub;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_sda_en <= n_sda_en;
            r_ack    <= n_ack;
            r_read   <= n_read;
        end
    end

    // Checks
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.done_res |-> !o_result.busy_res)
        else $error("done reported while a sequence is still running");

    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.rejected |-> (busy && !o_result.done_res))
        else $error("command rejected while idle");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == CMD_IDLE) |-> (r_phase == 6'd0 && r_div == 16'd0 && r_sub == RD_SLOT_HIGH))
        else $error("phase counters not cleared while idle");

    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == CMD_READ) |-> (r_sub <= RD_SLOT_IDLE))
        else $error("read bit slot out of range");

endmodule

`default_nettype wire

// File: rtl/i2c_master_byte_engine.sv
`default_nettype none

// Bit-level I2C master. Command items (start, stop, ack, write byte, read byte)
// start a pin sequence; tick items advance it one bus phase every phase_ticks
// ticks and carry the sampled SDA level. Every accepted item, tick or command,
// returns exactly one result with the SCL/SDA drive, busy, a done pulse, the
// last read byte, the last write acknowledge and a flag for a command refused
// while busy. One item is taken per clock while the result register is free or
// its result is taken; the item is registered on acceptance and its result is
// loaded into the result register when the item steps. The combinational
// next-state step of the phase engine sets that rate. The user writes
// phase_ticks through the configuration channel only while idle; not enforced.
module i2c_master_byte_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire i2cm_pkg::t_in_item i_in_item,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output i2cm_pkg::t_out_item     o_out_item,
    input  wire logic               i_cfg_valid,
    output      logic               o_cfg_ready,
    input  wire logic [15:0]        i_cfg_data
);
    import i2cm_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [15:0] r_phase_ticks;
    logic        step;
    logic        in_fire;
    t_out_item   result;

    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= 16'd1;
        end else if (i_cfg_valid) begin
            r_phase_ticks <= i_cfg_data;
        end
    end

    // Input and result valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire)   r_in_valid <= 1'b1;
            else if (step) r_in_valid <= 1'b0;
            if (step)             r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) r_in_item  <= i_in_item;
        if (step)    r_out_item <= result;
    end

    i2cm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (r_in_item),
        .i_phase_ticks (r_phase_ticks),
        .o_result      (result)
    );

    // Checks
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_item)))
        else $error("stalled result overwritten");

    a_step_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room downstream");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in_item)))
        else $error("held input item lost");

endmodule

`default_nettype wire
